// File: rtl/obq_pkg.sv
`timescale 1ns / 1ps
package obq_pkg;

   localparam int unsigned CoordW   = 20;
   localparam int unsigned AxisW    = 16;
   localparam int unsigned DiffW    = 21;
   localparam int unsigned ProdW    = 37;
   localparam int unsigned AccW     = 39;
   localparam int unsigned LocW     = 25;
   localparam int unsigned ErrW     = 26;
   localparam int unsigned SqW      = 52;
   localparam int unsigned SumW     = 54;
   localparam int unsigned RadW     = 40;
   localparam int unsigned RootW    = 20;
   localparam int unsigned RemW     = 23;
   localparam int unsigned RoundSh  = 14;
   localparam int unsigned AddrW    = 6;
   localparam int unsigned DataW    = 64;

   localparam logic [AccW-1:0] RoundHalf = AccW'(8192);

   localparam logic [2:0] REG_AXIS_X = 3'd0;
   localparam logic [2:0] REG_AXIS_Y = 3'd1;
   localparam logic [2:0] REG_AXIS_Z = 3'd2;
   localparam logic [2:0] REG_CENTER = 3'd3;
   localparam logic [2:0] REG_SPANS  = 3'd4;
   localparam logic [2:0] REG_MARGIN = 3'd5;

   localparam logic [47:0] AxisXReset = 48'h0000_0000_4000;
   localparam logic [47:0] AxisYReset = 48'h0000_4000_0000;
   localparam logic [47:0] AxisZReset = 48'h4000_0000_0000;

   typedef struct packed {
      logic signed [CoordW-1:0] point_x;
      logic signed [CoordW-1:0] point_y;
      logic signed [CoordW-1:0] point_z;
   } req_type;

   typedef struct packed {
      logic signed [CoordW-1:0] closest_x;
      logic signed [CoordW-1:0] closest_y;
      logic signed [CoordW-1:0] closest_z;
      logic [CoordW-1:0]        distance;
      logic                     inside_res;
   } rsp_type;

   typedef struct packed {
      logic [2:0][47:0] axis;
      logic [59:0]      center;
      logic [59:0]      spans;
      logic [19:0]      margin;
   } cfg_type;

   typedef struct packed {
      logic signed [CoordW-1:0] closest_x;
      logic signed [CoordW-1:0] closest_y;
      logic signed [CoordW-1:0] closest_z;
      logic                     inside_res;
      logic                     dist_sat;
   } side_type;

   function automatic logic signed [AxisW-1:0] axis_comp(cfg_type c, int unsigned i,
                                                         int unsigned j);
      axis_comp = c.axis[i][AxisW*j +: AxisW];
   endfunction

endpackage

// File: rtl/obq_csr.sv
`timescale 1ns / 1ps
module obq_csr (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         psel,
   input  logic                         penable,
   input  logic                         pwrite,
   input  logic [obq_pkg::AddrW-1:0]    paddr,
   input  logic [obq_pkg::DataW-1:0]    pwdata,
   output logic [obq_pkg::DataW-1:0]    prdata,
   output logic                         pready,
   output obq_pkg::cfg_type             cfg
);
   import obq_pkg::*;

   cfg_type    cfg_ff;
   logic [2:0] idx;
   logic       wr;

   assign idx    = paddr[AddrW-1:3];
   assign wr     = psel && penable && pwrite;
   assign pready = 1'b1;
   assign cfg    = cfg_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.axis[0] <= AxisXReset;
         cfg_ff.axis[1] <= AxisYReset;
         cfg_ff.axis[2] <= AxisZReset;
         cfg_ff.center  <= '0;
         cfg_ff.spans   <= '0;
         cfg_ff.margin  <= '0;
      end else if (wr) begin
         case (idx)
            REG_AXIS_X: cfg_ff.axis[0] <= pwdata[47:0];
            REG_AXIS_Y: cfg_ff.axis[1] <= pwdata[47:0];
            REG_AXIS_Z: cfg_ff.axis[2] <= pwdata[47:0];
            REG_CENTER: cfg_ff.center  <= pwdata[59:0];
            REG_SPANS:  cfg_ff.spans   <= pwdata[59:0];
            REG_MARGIN: cfg_ff.margin  <= pwdata[19:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (idx)
         REG_AXIS_X: prdata = {16'd0, cfg_ff.axis[0]};
         REG_AXIS_Y: prdata = {16'd0, cfg_ff.axis[1]};
         REG_AXIS_Z: prdata = {16'd0, cfg_ff.axis[2]};
         REG_CENTER: prdata = {4'd0, cfg_ff.center};
         REG_SPANS:  prdata = {4'd0, cfg_ff.spans};
         REG_MARGIN: prdata = {44'd0, cfg_ff.margin};
         default:    prdata = '0;
      endcase
   end

endmodule

// File: rtl/obq_geom.sv
`timescale 1ns / 1ps
module obq_geom (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        en,
   input  obq_pkg::cfg_type            cfg,
   input  logic                        in_valid,
   input  obq_pkg::req_type            in_data,
   output logic                        out_valid,
   output logic [obq_pkg::RadW-1:0]    out_rad,
   output obq_pkg::side_type           out_side
);
   import obq_pkg::*;

   logic [5:0] vld_ff;

   logic signed [2:0][DiffW-1:0]      diff_ff, diff_in;
   logic signed [2:0][2:0][ProdW-1:0] fprod_ff, fprod_in;
   logic signed [2:0][LocW-1:0]       loc_ff, loc_in;
   logic signed [2:0][DiffW-1:0]      clmp_ff, clmp_in;
   logic signed [2:0][ErrW-1:0]       err_ff, err_in;
   logic [2:0]                        ins_ff, ins_in;
   logic signed [2:0][2:0][ProdW-1:0] bprod_ff, bprod_in;
   logic [2:0][SqW-1:0]               sq_ff, sq_in;
   logic                              ins5_ff;
   logic [RadW-1:0]                   rad_ff, rad_in;
   side_type                          side_ff, side_in;

   logic signed [2:0][CoordW-1:0] pt;
   logic signed [2:0][CoordW-1:0] ctr;

   assign pt[0] = in_data.point_x;
   assign pt[1] = in_data.point_y;
   assign pt[2] = in_data.point_z;

   always_comb begin
      logic signed [AccW-1:0]   acc;
      logic signed [DiffW-1:0]  h;
      logic signed [ErrW-1:0]   lim;
      logic signed [ErrW-1:0]   locx;
      logic [SumW-1:0]          ssum;
      logic signed [LocW:0]     cw;
      logic signed [2:0][CoordW-1:0] cl;
      for (int j = 0; j < 3; j++) begin
         ctr[j]     = cfg.center[CoordW*j +: CoordW];
         diff_in[j] = DiffW'($signed(pt[j])) - DiffW'($signed(ctr[j]));
      end
      for (int i = 0; i < 3; i++) begin
         for (int j = 0; j < 3; j++) begin
            fprod_in[i][j] = ProdW'(axis_comp(cfg, i, j)) * ProdW'($signed(diff_ff[j]));
            bprod_in[j][i] = ProdW'(axis_comp(cfg, i, j)) * ProdW'($signed(clmp_ff[i]));
         end
      end
      for (int i = 0; i < 3; i++) begin
         acc = AccW'($signed(fprod_ff[i][0])) + AccW'($signed(fprod_ff[i][1]))
               + AccW'($signed(fprod_ff[i][2])) + RoundHalf;
         loc_in[i] = acc[AccW-1:RoundSh];
      end
      for (int i = 0; i < 3; i++) begin
         h    = {1'b0, cfg.spans[CoordW*i +: CoordW]};
         locx = ErrW'($signed(loc_ff[i]));
         if (locx > ErrW'(h))
            clmp_in[i] = h;
         else if (locx < -ErrW'(h))
            clmp_in[i] = -h;
         else
            clmp_in[i] = DiffW'(loc_ff[i]);
         err_in[i] = locx - ErrW'($signed(clmp_in[i]));
         lim       = ErrW'(h) + ErrW'($signed(cfg.margin));
         ins_in[i] = (locx < lim) && (locx > -lim);
         sq_in[i]  = SqW'($signed(err_ff[i]) * $signed(err_ff[i]));
      end
      ssum = SumW'(sq_ff[0]) + SumW'(sq_ff[1]) + SumW'(sq_ff[2]);
      rad_in = ssum[RadW-1:0];
      for (int j = 0; j < 3; j++) begin
         acc = AccW'($signed(bprod_ff[j][0])) + AccW'($signed(bprod_ff[j][1]))
               + AccW'($signed(bprod_ff[j][2])) + RoundHalf;
         cw  = (LocW+1)'($signed(acc[AccW-1:RoundSh])) + (LocW+1)'($signed(ctr[j]));
         if (cw > (LocW+1)'(524287))
            cl[j] = 20'sh7FFFF;
         else if (cw < -(LocW+1)'(524288))
            cl[j] = 20'sh80000;
         else
            cl[j] = cw[CoordW-1:0];
      end
      side_in.closest_x  = cl[0];
      side_in.closest_y  = cl[1];
      side_in.closest_z  = cl[2];
      side_in.inside_res = ins5_ff;
      side_in.dist_sat   = |ssum[SumW-1:RadW];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (en) begin
         vld_ff <= {vld_ff[4:0], in_valid};
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         diff_ff  <= diff_in;
         fprod_ff <= fprod_in;
         loc_ff   <= loc_in;
         clmp_ff  <= clmp_in;
         err_ff   <= err_in;
         ins_ff   <= ins_in;
         bprod_ff <= bprod_in;
         sq_ff    <= sq_in;
         ins5_ff  <= &ins_ff;
         rad_ff   <= rad_in;
         side_ff  <= side_in;
      end
   end

   assign out_valid = vld_ff[5];
   assign out_rad   = rad_ff;
   assign out_side  = side_ff;

endmodule

// File: rtl/obq_sqrt.sv
`timescale 1ns / 1ps
module obq_sqrt (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      en,
   input  logic                      in_valid,
   input  logic [obq_pkg::RadW-1:0]  in_rad,
   input  obq_pkg::side_type         in_side,
   output logic                      out_valid,
   output obq_pkg::rsp_type          out_data
);
   import obq_pkg::*;

   logic [RootW-1:0]              vld_ff;
   logic [RootW-1:0][RemW-1:0]    rem_ff, rem_in;
   logic [RootW-1:0][RootW-1:0]   root_ff, root_in;
   logic [RootW-1:0][RadW-1:0]    rest_ff, rest_in;
   side_type [RootW-1:0]          side_ff;

   always_comb begin
      logic [RemW-1:0]  rem;
      logic [RemW-1:0]  trial;
      logic [RootW-1:0] root;
      logic [RadW-1:0]  rest;
      for (int k = 0; k < RootW; k++) begin
         if (k == 0) begin
            rem  = '0;
            root = '0;
            rest = in_rad;
         end else begin
            rem  = rem_ff[k-1];
            root = root_ff[k-1];
            rest = rest_ff[k-1];
         end
         rem   = {rem[RemW-3:0], rest[RadW-1:RadW-2]};
         trial = {1'b0, root, 2'b01};
         if (rem >= trial) begin
            rem_in[k]  = rem - trial;
            root_in[k] = {root[RootW-2:0], 1'b1};
         end else begin
            rem_in[k]  = rem;
            root_in[k] = {root[RootW-2:0], 1'b0};
         end
         rest_in[k] = {rest[RadW-3:0], 2'b00};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (en) begin
         vld_ff <= {vld_ff[RootW-2:0], in_valid};
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         rem_ff  <= rem_in;
         root_ff <= root_in;
         rest_ff <= rest_in;
         side_ff <= {side_ff[RootW-2:0], in_side};
      end
   end

   assign out_valid           = vld_ff[RootW-1];
   assign out_data.closest_x  = side_ff[RootW-1].closest_x;
   assign out_data.closest_y  = side_ff[RootW-1].closest_y;
   assign out_data.closest_z  = side_ff[RootW-1].closest_z;
   assign out_data.inside_res = side_ff[RootW-1].inside_res;
   assign out_data.distance   = side_ff[RootW-1].dist_sat ? '1 : root_ff[RootW-1];

endmodule

// File: rtl/oriented_box_point_query.sv
`timescale 1ns / 1ps
// channel   direction  handshake             payload
// req       in         req_valid/req_stall   req_data (point_x, point_y, point_z)
// rsp       out        rsp_valid/rsp_stall   rsp_data (closest xyz, distance, inside_res)
// csr       in         psel/penable/pwrite   paddr, pwdata, prdata, pready
// one transfer per cycle while rsp_stall does not hold the pipeline: six geometry
// stages then a twenty stage square root, one root bit per stage
// the whole pipeline holds while a result sits on rsp and rsp_stall is high
// synchronous active high reset clears valid bits and resets csr registers; datapath registers are not reset
module oriented_box_point_query (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_stall,
   input  obq_pkg::req_type            req_data,
   output logic                        rsp_valid,
   input  logic                        rsp_stall,
   output obq_pkg::rsp_type            rsp_data,
   input  logic                        psel,
   input  logic                        penable,
   input  logic                        pwrite,
   input  logic [obq_pkg::AddrW-1:0]   paddr,
   input  logic [obq_pkg::DataW-1:0]   pwdata,
   output logic [obq_pkg::DataW-1:0]   prdata,
   output logic                        pready
);
   import obq_pkg::*;

   cfg_type         cfg;
   logic            en;
   logic            g_valid;
   logic [RadW-1:0] g_rad;
   side_type        g_side;

   assign en        = !(rsp_valid && rsp_stall);
   assign req_stall = !en;

   obq_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   obq_geom u_geom (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .cfg       (cfg),
      .in_valid  (req_valid),
      .in_data   (req_data),
      .out_valid (g_valid),
      .out_rad   (g_rad),
      .out_side  (g_side)
   );

   obq_sqrt u_sqrt (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (g_valid),
      .in_rad    (g_rad),
      .in_side   (g_side),
      .out_valid (rsp_valid),
      .out_data  (rsp_data)
   );

endmodule
